// File: rtl/core/node_address_registry_macros.svh
// ----------------------------------------------------------------------------
// node_address_registry_macros
// Assertion macros used by the node address registry top level.
// ----------------------------------------------------------------------------
`ifndef NODE_ADDRESS_REGISTRY_MACROS_SVH
`define NODE_ADDRESS_REGISTRY_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nar_pkg.sv
// ----------------------------------------------------------------------------
// nar_pkg
// Widths, command and status codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package nar_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int UID_W    = 64;
  localparam int ADDR_W   = 7;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONFIRM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADARG   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef logic [3:0] fin_kind_t;

  localparam fin_kind_t FIN_BADARG   = 4'd0;
  localparam fin_kind_t FIN_HIT      = 4'd1;
  localparam fin_kind_t FIN_ALLOC    = 4'd2;
  localparam fin_kind_t FIN_FULL     = 4'd3;
  localparam fin_kind_t FIN_CONFLICT = 4'd4;
  localparam fin_kind_t FIN_BIND     = 4'd5;
  localparam fin_kind_t FIN_QUERY    = 4'd6;
  localparam fin_kind_t FIN_NEXT     = 4'd7;
  localparam fin_kind_t FIN_NOTFOUND = 4'd8;

  typedef struct packed {
    logic      load;
    logic      scan_start;
    logic      scan_step;
    logic      fin;
    fin_kind_t fin_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             present;
    logic             addr_ok;
    logic             hit;
    logic             rd_pend;
    logic             scan_done;
    logic             free_found;
    logic             conflict;
    logic             cur_valid;
    logic             scan_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/nar_ctrl.sv
// ----------------------------------------------------------------------------
// nar_ctrl
// Command sequencer: dispatches each beat and steps the datapath scans.
// ----------------------------------------------------------------------------
`default_nettype none

module nar_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  nar_pkg::dp_sts_t sts,
  output nar_pkg::dp_cmd_t cmd
);
  import nar_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_REQ  = 3'd2;
  localparam logic [2:0] S_CCHK = 3'd3;
  localparam logic [2:0] S_NXT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_REQUEST: begin
            if (!sts.present) begin
              cmd.fin      = 1'b1;
              cmd.fin_kind = FIN_BADARG;
              state_nxt    = S_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_REQ;
            end
          end
          CMD_CONFIRM: begin
            if (!sts.present || !sts.addr_ok) begin
              cmd.fin      = 1'b1;
              cmd.fin_kind = FIN_BADARG;
              state_nxt    = S_IDLE;
            end else begin
              state_nxt = S_CCHK;
            end
          end
          CMD_QUERY: begin
            cmd.fin      = 1'b1;
            cmd.fin_kind = FIN_QUERY;
            state_nxt    = S_IDLE;
          end
          default: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_NXT;
          end
        endcase
      end
      S_REQ: begin
        if (sts.hit) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = FIN_HIT;
          state_nxt    = S_IDLE;
        end else if (sts.scan_done && !sts.rd_pend) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = sts.free_found ? FIN_ALLOC : FIN_FULL;
          state_nxt    = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CCHK: begin
        cmd.fin      = 1'b1;
        cmd.fin_kind = sts.conflict ? FIN_CONFLICT : FIN_BIND;
        state_nxt    = S_IDLE;
      end
      S_NXT: begin
        if (sts.cur_valid) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = FIN_NEXT;
          state_nxt    = S_IDLE;
        end else if (sts.scan_last) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = FIN_NOTFOUND;
          state_nxt    = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/nar_dp.sv
// ----------------------------------------------------------------------------
// nar_dp
// Datapath: UID memory, valid bits, scan counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module nar_dp #(
  parameter int ENTRIES = nar_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [nar_pkg::CMD_W-1:0]      in_cmd,
  input  logic [nar_pkg::UID_W-1:0]      in_uid_key,
  input  logic                           in_uid_present,
  input  logic [nar_pkg::ADDR_W-1:0]     in_address,
  input  nar_pkg::dp_cmd_t               cmd,
  output nar_pkg::dp_sts_t               sts,
  output logic                           out_valid,
  output logic [nar_pkg::ADDR_W-1:0]     out_result_address,
  output logic [nar_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_is_new
);
  import nar_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // latched beat
  logic [CMD_W-1:0]  cmd_r;
  logic [UID_W-1:0]  key_r;
  logic              pres_r;
  logic [ADDR_W-1:0] addr_r;

  logic [UID_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [UID_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [IW-1:0]     rd_addr;

  logic [IW-1:0]     scan_idx_r;
  logic [IW-1:0]     scan_idx_inc;
  logic [CW-1:0]     scan_cnt_r;
  logic              scan_done;
  logic              rd_pend_r;
  logic [IW-1:0]     rd_idx_r;
  logic              free_found_r;
  logic [IW-1:0]     free_idx_r;

  logic              addr_ok;
  logic [ADDR_W-1:0] addr_m1;
  logic [IW-1:0]     slot;

  logic              wr_en;
  logic [IW-1:0]     wr_idx;

  logic [IW-1:0]     idx_sel;
  logic [IW:0]       idx_sum;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic [ADDR_W-1:0]   res_addr_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                is_new_r;
  logic                is_new_nxt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      key_r  <= in_uid_key;
      pres_r <= in_uid_present;
      addr_r <= in_address;
    end
  end

  assign addr_ok = (addr_r != '0) && (int'(addr_r) <= ENTRIES);
  assign addr_m1 = addr_r - ADDR_W'(1);
  assign slot    = IW'(addr_m1);

  assign rd_addr = (cmd_r == CMD_CONFIRM) ? slot : scan_idx_r;

  assign wr_en  = cmd.fin && ((cmd.fin_kind == FIN_ALLOC) || (cmd.fin_kind == FIN_BIND));
  assign wr_idx = (cmd.fin_kind == FIN_ALLOC) ? free_idx_r : slot;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= key_r;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  assign scan_idx_inc = (scan_idx_r == IW'(ENTRIES - 1)) ? '0 : scan_idx_r + 1'b1;
  assign scan_done    = (scan_cnt_r == CW'(ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      scan_cnt_r   <= '0;
      rd_pend_r    <= 1'b0;
      rd_idx_r     <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else if (cmd.scan_start) begin
      scan_idx_r   <= ((cmd_r == CMD_NEXT) && addr_ok) ? slot : '0;
      scan_cnt_r   <= '0;
      rd_pend_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!scan_done) begin
        scan_idx_r <= scan_idx_inc;
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      rd_pend_r <= !scan_done;
      rd_idx_r  <= scan_idx_r;
      // hold the lowest free slot seen
      if (rd_pend_r && !rd_vld_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.cmd        = cmd_r;
    sts.present    = pres_r;
    sts.addr_ok    = addr_ok;
    sts.hit        = rd_pend_r && rd_vld_r && (rd_data_r == key_r);
    sts.rd_pend    = rd_pend_r;
    sts.scan_done  = scan_done;
    sts.free_found = free_found_r;
    sts.conflict   = rd_vld_r && (rd_data_r != key_r);
    sts.cur_valid  = valid_r[scan_idx_r];
    sts.scan_last  = (scan_cnt_r == CW'(ENTRIES - 1));
  end

  always_comb begin
    case (cmd.fin_kind)
      FIN_HIT:   idx_sel = rd_idx_r;
      FIN_ALLOC: idx_sel = free_idx_r;
      default:   idx_sel = scan_idx_r;
    endcase
  end

  assign idx_sum = {1'b0, idx_sel} + 1'b1;

  always_comb begin
    res_addr_nxt = '0;
    status_nxt   = ST_OK;
    is_new_nxt   = 1'b0;
    case (cmd.fin_kind)
      FIN_BADARG: begin
        status_nxt = ST_BADARG;
      end
      FIN_HIT: begin
        res_addr_nxt = ADDR_W'(idx_sum);
      end
      FIN_ALLOC: begin
        res_addr_nxt = ADDR_W'(idx_sum);
        is_new_nxt   = 1'b1;
      end
      FIN_FULL: begin
        status_nxt = ST_FULL;
      end
      FIN_CONFLICT: begin
        status_nxt = ST_CONFLICT;
      end
      FIN_BIND: begin
        res_addr_nxt = addr_r;
      end
      FIN_QUERY: begin
        if (!addr_ok) begin
          status_nxt = ST_BADARG;
        end else if (valid_r[slot]) begin
          res_addr_nxt = addr_r;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      FIN_NEXT: begin
        res_addr_nxt = ADDR_W'(idx_sum);
      end
      default: begin
        status_nxt = ST_NOTFOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_addr_r <= res_addr_nxt;
      status_r   <= status_nxt;
      is_new_r   <= is_new_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = res_addr_r;
  assign out_status         = status_r;
  assign out_is_new         = is_new_r;

endmodule

`default_nettype wire

// File: rtl/core/node_address_registry.sv
// ----------------------------------------------------------------------------
// node_address_registry
// Maps 64-bit device UIDs to node addresses 1..ENTRIES.
//
//   channel  ports                                          handshake
//   input    in_cmd in_uid_key in_uid_present in_address    start & !busy
//   result   out_result_address out_status out_is_new       out_valid strobe
//
// One beat at a time. Query finishes in the dispatch state, confirm reads the
// addressed slot and then checks it, and next and request scan: request walks
// the UID memory one entry per cycle through its single read port, next walks
// the valid bits one per cycle. busy drops in the strobe cycle, so a new beat
// may be taken there. Synchronous reset clears the valid bits at once; the UID
// memory needs no clearing pass. The receiver cannot stall the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_address_registry_macros.svh"

module node_address_registry #(
  parameter int ENTRIES = nar_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [nar_pkg::CMD_W-1:0]      in_cmd,
  input  logic [nar_pkg::UID_W-1:0]      in_uid_key,
  input  logic                           in_uid_present,
  input  logic [nar_pkg::ADDR_W-1:0]     in_address,
  output logic                           out_valid,
  output logic [nar_pkg::ADDR_W-1:0]     out_result_address,
  output logic [nar_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_is_new
);
  import nar_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  nar_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (dp_sts),
    .cmd   (dp_cmd)
  );

  nar_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_uid_key         (in_uid_key),
    .in_uid_present     (in_uid_present),
    .in_address         (in_address),
    .cmd                (dp_cmd),
    .sts                (dp_sts),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_is_new         (out_is_new)
  );

  `NAR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `NAR_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
  `NAR_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while sequencer busy")
  `NAR_ASSERT_IMP(a_new_ok, out_valid && out_is_new, out_status == ST_OK, "fresh slot with bad status")

endmodule

`default_nettype wire
